/* hdl/bmm_pkg.sv */
// Package for the 3x3 binary morphology unit: geometry limits, register
// indexes, mode codes, position type and the window evaluation functions.
// No dependencies.
package bmm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CNT_W   = $clog2(2 * (MAX_WIDTH + 1) + 1);
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(3);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic pixel_out;
    logic end_of_frame;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Position leaving a stage, one row plus one pixel behind (row, col).
  function automatic pos_t stage_pos(input logic [ROW_W-1:0] row,
                                     input logic [COL_W-1:0] col,
                                     input logic [DIM_W-1:0] w,
                                     input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] re;
    logic [DIM_W-1:0] ce;
    logic [DIM_W-1:0] orow;
    logic [DIM_W-1:0] ocol;
    pos_t p;
    re = DIM_W'(row);
    ce = DIM_W'(col);
    if (ce != '0) begin
      ocol = ce - DIM_W'(1);
      orow = (re != '0) ? re - DIM_W'(1) : h - DIM_W'(1);
    end else begin
      ocol = w - DIM_W'(1);
      orow = (re >= DIM_W'(2)) ? re - DIM_W'(2) : re + h - DIM_W'(2);
    end
    p.row = orow[ROW_W-1:0];
    p.col = ocol[COL_W-1:0];
    return p;
  endfunction

  // Interior flags of rows o-1, o, o+1.
  function automatic logic [2:0] row_int3(input logic [ROW_W-1:0] o,
                                          input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] oe;
    logic [2:0] f;
    oe = DIM_W'(o);
    f[0] = (oe >= DIM_W'(2)) && (oe <= h - DIM_W'(1));
    f[1] = (oe >= DIM_W'(1)) && (oe <= h - DIM_W'(2));
    f[2] = (oe <= h - DIM_W'(3));
    return f;
  endfunction

  // Interior flags of columns o-1, o, o+1.
  function automatic logic [2:0] col_int3(input logic [COL_W-1:0] o,
                                          input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] oe;
    logic [2:0] f;
    oe = DIM_W'(o);
    f[0] = (oe >= DIM_W'(2)) && (oe <= w - DIM_W'(1));
    f[1] = (oe >= DIM_W'(1)) && (oe <= w - DIM_W'(2));
    f[2] = (oe <= w - DIM_W'(3));
    return f;
  endfunction

  function automatic logic [8:0] dil_mask(input logic [2:0] ri, input logic [2:0] ci);
    logic [8:0] m;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        m[3*k+j] = ci[k] & ri[j];
      end
    end
    return m;
  endfunction

endpackage

/* hdl/bmm_if.sv */
// Channel interfaces of the 3x3 binary morphology unit: pixel input,
// result output and register write. Depends on bmm_pkg.
interface bmm_in_if;
  logic valid;
  logic ready;
  logic command;
  logic pixel_in;
  modport source(output valid, output command, output pixel_in, input ready);
  modport sink(input valid, input command, input pixel_in, output ready);
endinterface

interface bmm_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic end_of_frame;
  modport source(output valid, output pixel_out, output end_of_frame, input ready);
  modport sink(input valid, input pixel_out, input end_of_frame, output ready);
endinterface

interface bmm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bmm_pkg::CFG_IDX_W-1:0]  index;
  logic [bmm_pkg::DIM_W-1:0]      data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* hdl/binary_morphology_3x3_unit.sv */
// Streaming 3x3 binary erode / dilate / open over a raster pixel stream.
// Depends on bmm_pkg and the channel interfaces in bmm_if.sv.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | command, pixel_in
//  out_ch   | out | valid / ready | pixel_out, end_of_frame
//  cfg_ch   | in  | valid / ready | index, data (cfg_ch.ready is always high)
//
// One pixel per cycle sustained while the result queue has room. Each item
// passes three stages: position and erode line-store read, erode update and
// dilate line-store read, dilate update; stage C pushes results to the queue.
// Line stores need no clearing after reset; input stalls only when the
// four-entry result queue plus the items still in flight would overflow it.
module binary_morphology_3x3_unit (
  input  logic          clk,
  input  logic          rst_n,
  bmm_in_if.sink        in_ch,
  bmm_out_if.source     out_ch,
  bmm_cfg_if.sink       cfg_ch
);

  // configuration
  logic [bmm_pkg::MODE_W-1:0]  mode_r;
  logic [bmm_pkg::DIM_W-1:0]   fw_r;
  logic [bmm_pkg::DIM_W-1:0]   fh_r;
  logic                        cfg_fire;
  logic                        cfg_hit;

  // frame position
  logic [bmm_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [bmm_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [bmm_pkg::CNT_W-1:0]   pend_r, pend_nxt;

  logic [bmm_pkg::DIM_W-1:0]   w, h;
  logic [bmm_pkg::COL_W-1:0]   cc;
  logic [bmm_pkg::ROW_W-1:0]   rc;
  logic [bmm_pkg::CNT_W-1:0]   lat, lat1, pend_dec;
  logic [bmm_pkg::DIM_W-1:0]   c_inc, r_inc;
  logic                        in_fire, item_go, emit_a, reach, bit_a;

  // stage B
  logic                        b_valid_r, b_emit_r, b_bit_r;
  logic [bmm_pkg::MODE_W-1:0]  b_mode_r;
  logic [bmm_pkg::ROW_W-1:0]   b_row_r;
  logic [bmm_pkg::COL_W-1:0]   b_col_r;

  // stage C
  logic                        c_valid_r, c_emit_r, c_bit_r, c_eval_r, c_eeof_r;
  logic [bmm_pkg::MODE_W-1:0]  c_mode_r;
  logic [bmm_pkg::ROW_W-1:0]   c_row_r;
  logic [bmm_pkg::COL_W-1:0]   c_col_r;

  // erode line store
  logic [1:0]                  e_mem [bmm_pkg::MAX_WIDTH];
  logic [1:0]                  e_rd_r, e_fwd_word_r, e_word, e_wd;
  logic                        e_fwd_r, e_we, e_re;
  logic [bmm_pkg::COL_W-1:0]   e_wa, e_ra;
  logic [8:0]                  e_win_r, e_win_nxt;
  bmm_pkg::pos_t               e_pos;
  logic [2:0]                  e_ri, e_ci;
  logic                        e_val, e_eof;

  // dilate line store
  logic [1:0]                  d_mem [bmm_pkg::MAX_WIDTH];
  logic [1:0]                  d_rd_r, d_fwd_word_r, d_word, d_wd;
  logic                        d_fwd_r, d_we, d_re;
  logic [bmm_pkg::COL_W-1:0]   d_wa, d_ra;
  logic [8:0]                  d_win_r, d_win_nxt;
  bmm_pkg::pos_t               d_pos;
  logic                        d_val, d_eof;
  logic [bmm_pkg::ROW_W-1:0]   din_row;
  logic [bmm_pkg::COL_W-1:0]   din_col;
  logic                        din_bit;

  // result queue
  bmm_pkg::res_t               fifo_q [bmm_pkg::FIFO_DEPTH];
  bmm_pkg::res_t               res_c;
  logic [bmm_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bmm_pkg::FIFO_CNT_W-1:0] fifo_cnt_r, occ;
  logic                        push, pop;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit      = cfg_fire && (cfg_ch.index <= bmm_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bmm_pkg::MODE_OPEN;
      fw_r   <= bmm_pkg::WIDTH_RST;
      fh_r   <= bmm_pkg::HEIGHT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        bmm_pkg::REG_MODE:   mode_r <= cfg_ch.data[bmm_pkg::MODE_W-1:0];
        bmm_pkg::REG_WIDTH:  fw_r   <= cfg_ch.data;
        bmm_pkg::REG_HEIGHT: fh_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage A
  assign w = bmm_pkg::clamp_dim(fw_r, bmm_pkg::DIM_W'(bmm_pkg::MAX_WIDTH));
  assign h = bmm_pkg::clamp_dim(fh_r, bmm_pkg::DIM_W'(bmm_pkg::MAX_HEIGHT));

  assign occ = fifo_cnt_r + bmm_pkg::FIFO_CNT_W'(b_valid_r && b_emit_r)
                          + bmm_pkg::FIFO_CNT_W'(c_valid_r && c_emit_r);
  assign in_ch.ready = (occ < bmm_pkg::FIFO_CNT_W'(bmm_pkg::FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign item_go     = in_fire && !(in_ch.command && (pend_r == '0));
  assign bit_a       = !in_ch.command && in_ch.pixel_in;

  always_comb begin
    rc = row_r;
    cc = col_r;
    if ((bmm_pkg::DIM_W'(row_r) >= h) || (bmm_pkg::DIM_W'(col_r) >= w)) begin
      rc = '0;
      cc = '0;
    end
    lat1 = bmm_pkg::CNT_W'(w) + bmm_pkg::CNT_W'(1);
    lat  = mode_r[1] ? (lat1 << 1) : lat1;
    if (mode_r[1]) begin
      reach = (rc >= bmm_pkg::ROW_W'(3)) ||
              ((rc == bmm_pkg::ROW_W'(2)) && (cc >= bmm_pkg::COL_W'(2)));
    end else begin
      reach = (rc >= bmm_pkg::ROW_W'(2)) ||
              ((rc == bmm_pkg::ROW_W'(1)) && (cc >= bmm_pkg::COL_W'(1)));
    end
    emit_a   = (pend_r != '0) || reach;
    pend_dec = (pend_r != '0) ? pend_r - bmm_pkg::CNT_W'(1) : pend_r;
    c_inc    = bmm_pkg::DIM_W'(cc) + bmm_pkg::DIM_W'(1);
    r_inc    = bmm_pkg::DIM_W'(rc) + bmm_pkg::DIM_W'(1);

    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (item_go) begin
      pend_nxt = pend_dec;
      if (in_ch.command && (pend_dec == '0)) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (c_inc == w) begin
        col_nxt = '0;
        if (r_inc == h) begin
          row_nxt  = '0;
          pend_nxt = lat;
        end else begin
          row_nxt = r_inc[bmm_pkg::ROW_W-1:0];
        end
      end else begin
        col_nxt = c_inc[bmm_pkg::COL_W-1:0];
        row_nxt = rc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      pend_r    <= '0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pend_r    <= pend_nxt;
      b_valid_r <= item_go;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_emit_r <= emit_a;
    b_mode_r <= mode_r;
    b_row_r  <= rc;
    b_col_r  <= cc;
    b_bit_r  <= bit_a;
  end

  // ---------------------------------------------------------------- erode store
  assign e_re = item_go;
  assign e_ra = cc;

  always_ff @(posedge clk) begin
    if (e_we) e_mem[e_wa] <= e_wd;
    if (e_re) e_rd_r <= e_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_fwd_r <= 1'b0;
    end else begin
      e_fwd_r <= e_we && e_re && (e_wa == e_ra);
    end
    e_fwd_word_r <= e_wd;
  end

  // ---------------------------------------------------------------- stage B
  always_comb begin
    e_word    = e_fwd_r ? e_fwd_word_r : e_rd_r;
    e_win_nxt = {b_bit_r, e_word[0], e_word[1], e_win_r[8:3]};
    e_we      = b_valid_r && (b_mode_r != bmm_pkg::MODE_DILATE);
    e_wa      = b_col_r;
    e_wd      = {e_word[0], b_bit_r};
    e_pos     = bmm_pkg::stage_pos(b_row_r, b_col_r, w, h);
    e_ri      = bmm_pkg::row_int3(e_pos.row, h);
    e_ci      = bmm_pkg::col_int3(e_pos.col, w);
    e_val     = e_ri[1] && e_ci[1] && (&e_win_nxt);
    e_eof     = (bmm_pkg::DIM_W'(e_pos.row) == h - bmm_pkg::DIM_W'(1)) &&
                (bmm_pkg::DIM_W'(e_pos.col) == w - bmm_pkg::DIM_W'(1));
    if (b_mode_r == bmm_pkg::MODE_DILATE) begin
      din_row = b_row_r;
      din_col = b_col_r;
      din_bit = b_bit_r;
    end else begin
      din_row = e_pos.row;
      din_col = e_pos.col;
      din_bit = e_val;
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) e_win_r <= e_win_nxt;
    c_emit_r <= b_emit_r;
    c_mode_r <= b_mode_r;
    c_row_r  <= din_row;
    c_col_r  <= din_col;
    c_bit_r  <= din_bit;
    c_eval_r <= e_val;
    c_eeof_r <= e_eof;
  end

  // ---------------------------------------------------------------- dilate store
  assign d_re = b_valid_r;
  assign d_ra = din_col;

  always_ff @(posedge clk) begin
    if (d_we) d_mem[d_wa] <= d_wd;
    if (d_re) d_rd_r <= d_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_fwd_r <= 1'b0;
    end else begin
      d_fwd_r <= d_we && d_re && (d_wa == d_ra);
    end
    d_fwd_word_r <= d_wd;
  end

  // ---------------------------------------------------------------- stage C
  always_comb begin
    d_word    = d_fwd_r ? d_fwd_word_r : d_rd_r;
    d_win_nxt = {c_bit_r, d_word[0], d_word[1], d_win_r[8:3]};
    d_we      = c_valid_r && (c_mode_r != bmm_pkg::MODE_ERODE);
    d_wa      = c_col_r;
    d_wd      = {d_word[0], c_bit_r};
    d_pos     = bmm_pkg::stage_pos(c_row_r, c_col_r, w, h);
    d_val     = |(d_win_nxt & bmm_pkg::dil_mask(bmm_pkg::row_int3(d_pos.row, h),
                                                bmm_pkg::col_int3(d_pos.col, w)));
    d_eof     = (bmm_pkg::DIM_W'(d_pos.row) == h - bmm_pkg::DIM_W'(1)) &&
                (bmm_pkg::DIM_W'(d_pos.col) == w - bmm_pkg::DIM_W'(1));
    if (c_mode_r == bmm_pkg::MODE_ERODE) begin
      res_c.pixel_out    = c_eval_r;
      res_c.end_of_frame = c_eeof_r;
    end else begin
      res_c.pixel_out    = d_val;
      res_c.end_of_frame = d_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) d_win_r <= d_win_nxt;
  end

  // ---------------------------------------------------------------- result queue
  assign push = c_valid_r && c_emit_r;
  assign pop  = out_ch.valid && out_ch.ready;

  assign out_ch.valid        = (fifo_cnt_r != '0);
  assign out_ch.pixel_out    = fifo_q[rd_ptr_r].pixel_out;
  assign out_ch.end_of_frame = fifo_q[rd_ptr_r].end_of_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + bmm_pkg::FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + bmm_pkg::FIFO_PTR_W'(1);
      fifo_cnt_r <= fifo_cnt_r + bmm_pkg::FIFO_CNT_W'(push) - bmm_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_q[wr_ptr_r] <= res_c;
  end

  // ---------------------------------------------------------------- checks
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (fifo_cnt_r == bmm_pkg::FIFO_CNT_W'(bmm_pkg::FIFO_DEPTH))))
    else $error("result queue overflow");

  a_erode_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    e_fwd_r |-> b_valid_r)
    else $error("erode forward without item in stage B");

  a_dilate_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    d_fwd_r |-> c_valid_r)
    else $error("dilate forward without item in stage C");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= bmm_pkg::CNT_W'(2 * (bmm_pkg::MAX_WIDTH + 1)))
    else $error("pending count out of range");

endmodule

/* tb/sv/binary_morphology_3x3_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for binary_morphology_3x3_unit: directed and random frames, with
// its own erode / dilate / open model in a scoreboard class. Depends on bmm_pkg, bmm_if.sv
// and the unit itself.

typedef enum bit {CMD_PIXEL = 1'b0, CMD_FLUSH = 1'b1} morph_cmd_t;
typedef enum int {STAGE_ERODE = 0, STAGE_DILATE = 1} morph_stage_t;

class morph_scoreboard;
  logic [bmm_pkg::MODE_W-1:0] mode_r;
  logic [bmm_pkg::DIM_W-1:0]  width_r;
  logic [bmm_pkg::DIM_W-1:0]  height_r;
  bit                         line_store [2][2*bmm_pkg::MAX_WIDTH];
  bit [8:0]                   window [2];
  int                         col_r;
  int                         row_r;
  int                         owed_r;
  bmm_pkg::res_t              expected_q [$];
  int                         errors;
  int                         taken;
  int                         results;
  int                         frame_ends;

  function new();
    mode_r   = bmm_pkg::MODE_OPEN;
    width_r  = bmm_pkg::WIDTH_RST;
    height_r = bmm_pkg::HEIGHT_RST;
    foreach (line_store[s, i]) line_store[s][i] = 1'b0;
    window[0] = '0;
    window[1] = '0;
  endfunction

  function int dim(logic [bmm_pkg::DIM_W-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function int eff_w();
    return dim(width_r, bmm_pkg::MAX_WIDTH);
  endfunction

  function int eff_h();
    return dim(height_r, bmm_pkg::MAX_HEIGHT);
  endfunction

  function int latency();
    return (mode_r >= bmm_pkg::MODE_OPEN ? 2 : 1) * (eff_w() + 1);
  endfunction

  function void write_reg(logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                          logic [bmm_pkg::DIM_W-1:0] value);
    case (idx)
      bmm_pkg::REG_MODE: mode_r = value[bmm_pkg::MODE_W-1:0];
      bmm_pkg::REG_WIDTH: width_r = value;
      bmm_pkg::REG_HEIGHT: height_r = value;
      default: return;
    endcase
    col_r  = 0;
    row_r  = 0;
    owed_r = 0;
  endfunction

  function bit interior(int r, int c, int w, int h);
    return r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2;
  endfunction

  // Shift one bit through a stage; returns the bit at (orow, ocol).
  function bit stage(morph_stage_t s, int r, int c, bit b, int w, int h,
                     output int orow, output int ocol);
    int col;
    bit top;
    bit mid;
    bit v;
    col = (c < bmm_pkg::MAX_WIDTH) ? c : bmm_pkg::MAX_WIDTH - 1;
    top = line_store[s][bmm_pkg::MAX_WIDTH + col];
    mid = line_store[s][col];
    line_store[s][bmm_pkg::MAX_WIDTH + col] = mid;
    line_store[s][col] = b;
    window[s] = {b, mid, top, window[s][8:3]};
    if (c >= 1) begin
      orow = (r >= 1) ? r - 1 : h - 1;
      ocol = c - 1;
    end else begin
      orow = (r >= 2) ? r - 2 : r + h - 2;
      ocol = w - 1;
    end
    v = 1'b0;
    if (s == STAGE_ERODE) begin
      v = interior(orow, ocol, w, h) && window[s] == 9'h1ff;
    end else begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (window[s][3*k+j] && interior(orow + j - 1, ocol + k - 1, w, h)) v = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function void note_input(bit cmd, bit pix);
    int w;
    int h;
    int lat;
    int r;
    int c;
    int n;
    int er;
    int ec;
    int orow;
    int ocol;
    bit b;
    bit ev;
    bit val;
    bit emit;
    bmm_pkg::res_t e;
    w   = eff_w();
    h   = eff_h();
    lat = latency();
    b   = (cmd == CMD_FLUSH) ? 1'b0 : pix;
    r   = row_r;
    c   = col_r;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    if (cmd == CMD_FLUSH && owed_r == 0) return;
    taken++;
    n = r * w + c;
    case (mode_r)
      bmm_pkg::MODE_ERODE: val = stage(STAGE_ERODE, r, c, b, w, h, orow, ocol);
      bmm_pkg::MODE_DILATE: val = stage(STAGE_DILATE, r, c, b, w, h, orow, ocol);
      default: begin
        ev  = stage(STAGE_ERODE, r, c, b, w, h, er, ec);
        val = stage(STAGE_DILATE, er, ec, ev, w, h, orow, ocol);
      end
    endcase
    emit = owed_r > 0 || n >= lat;
    if (owed_r > 0) owed_r--;
    if (cmd == CMD_FLUSH && owed_r == 0) begin
      col_r = 0;
      row_r = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          owed_r = lat;
        end
      end
      col_r = c;
      row_r = r;
    end
    if (emit) begin
      e.pixel_out    = val;
      e.end_of_frame = (orow == h - 1 && ocol == w - 1);
      expected_q.push_back(e);
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic pix, logic eof);
    bmm_pkg::res_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result pixel_out %b end_of_frame %b with none expected", pix, eof));
      return;
    end
    e = expected_q.pop_front();
    results++;
    if (pix !== e.pixel_out)
      report($sformatf("result %0d pixel_out %b, expected %b", results, pix, e.pixel_out));
    if (eof !== e.end_of_frame)
      report($sformatf("result %0d end_of_frame %b, expected %b", results, eof,
                       e.end_of_frame));
    if (e.end_of_frame) frame_ends++;
  endtask
endclass

module binary_morphology_3x3_unit_tb;

  localparam logic [bmm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DENSITY [6] = '{5, 30, 60, 90, 97, 100};

  logic clk;
  logic rst_n;
  bit   quiet;
  int   phase_count;

  bmm_in_if  in_ch();
  bmm_out_if out_ch();
  bmm_cfg_if cfg_ch();

  morph_scoreboard sb = new();

  binary_morphology_3x3_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.pixel_out, out_ch.end_of_frame);
      out_ch.ready <= quiet || $urandom_range(99) >= 32;
    end
  end

  task automatic drive_item(bit cmd, bit pix);
    while (!quiet && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, pix);
  endtask

  task automatic send_pixels(int count, int density);
    repeat (count) drive_item(CMD_PIXEL, $urandom_range(99) < density);
  endtask

  task automatic send_flushes(int count);
    repeat (count) drive_item(CMD_FLUSH, $urandom_range(1));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                           logic [bmm_pkg::DIM_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [bmm_pkg::DIM_W-1:0] mode_word(int m);
    logic [bmm_pkg::DIM_W-1:0] d;
    d = bmm_pkg::DIM_W'($urandom);
    d[bmm_pkg::MODE_W-1:0] = bmm_pkg::MODE_W'(m);
    return d;
  endfunction

  task automatic run_extreme(logic [bmm_pkg::DIM_W-1:0] w_data,
                             logic [bmm_pkg::DIM_W-1:0] h_data);
    settle();
    write_reg(bmm_pkg::REG_MODE, mode_word($urandom_range(3)));
    write_reg(bmm_pkg::REG_WIDTH, w_data);
    write_reg(bmm_pkg::REG_HEIGHT, h_data);
    send_pixels(sb.eff_w() * sb.eff_h(), DENSITY[$urandom_range(5)]);
    send_flushes(sb.latency());
  endtask

  task automatic run_phase();
    int sel;
    int frames;
    int area;
    int lat;
    logic [bmm_pkg::DIM_W-1:0] w_data;
    logic [bmm_pkg::DIM_W-1:0] h_data;
    settle();
    sel = $urandom_range(99);
    if (sel < 70) w_data = bmm_pkg::DIM_W'($urandom_range(3, 12));
    else if (sel < 85) w_data = bmm_pkg::DIM_W'($urandom_range(13, 40));
    else w_data = bmm_pkg::DIM_W'($urandom_range(2));
    sel = $urandom_range(99);
    if (sel < 75) h_data = bmm_pkg::DIM_W'($urandom_range(3, 8));
    else if (sel < 88) h_data = bmm_pkg::DIM_W'($urandom_range(9, 16));
    else h_data = bmm_pkg::DIM_W'($urandom_range(2));
    write_reg(bmm_pkg::REG_MODE, mode_word($urandom_range(3)));
    if ($urandom_range(9) < 8) write_reg(bmm_pkg::REG_WIDTH, w_data);
    if ($urandom_range(9) < 8) write_reg(bmm_pkg::REG_HEIGHT, h_data);
    if ($urandom_range(9) == 0) write_reg(REG_UNUSED, bmm_pkg::DIM_W'($urandom));
    area   = sb.eff_w() * sb.eff_h();
    lat    = sb.latency();
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        send_pixels($urandom_range(1, area - 1), DENSITY[$urandom_range(5)]);
        return;
      end
      send_pixels(area, DENSITY[$urandom_range(5)]);
      if (f == frames - 1) send_flushes(lat + $urandom_range(2));
      else if (sel <= 2) send_flushes($urandom_range(1, lat - 1));
      else if (sel == 3) send_flushes(lat);
    end
  endtask

  initial begin
    int base;
    int mark;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_PIXEL;
    in_ch.pixel_in  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= bmm_pkg::REG_MODE;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 640 wide, open, first results after two rows and two pixels
    send_pixels(1300, 90);
    settle();

    write_reg(bmm_pkg::REG_MODE, bmm_pkg::DIM_W'(bmm_pkg::MODE_ERODE));
    write_reg(bmm_pkg::REG_WIDTH, bmm_pkg::DIM_W'(3));
    write_reg(bmm_pkg::REG_HEIGHT, bmm_pkg::DIM_W'(3));
    send_flushes(1);
    send_pixels(9, 100);
    send_flushes(sb.latency() + 1);
    settle();
    write_reg(bmm_pkg::REG_MODE, {9'h1ff, bmm_pkg::MODE_DILATE});
    for (int i = 0; i < 9; i++) drive_item(CMD_PIXEL, i == 0 || i == 4);
    send_flushes(sb.latency());

    base = sb.taken;
    phase_count = 0;
    while (sb.taken - base < 900) begin
      quiet = phase_count >= 3 && phase_count < 7;
      mark = sb.taken;
      if (phase_count == 1) run_extreme(11'h7ff, 11'd1);
      if (phase_count == 4) run_extreme(11'd0, 11'd1024);
      base += sb.taken - mark;
      run_phase();
      phase_count++;
    end
    quiet = 1'b0;
    settle();

    $display("covered %0d accepted items over %0d random configurations", sb.taken,
             phase_count);
    $display("checked %0d results, %0d of them frame ends", sb.results, sb.frame_ends);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
